// ===== design/pcfp_pkg.sv =====
// Shared types, constants and helpers for the PWM channel frame packer.
package pcfp_pkg;

  localparam int MaxDrivers        = 4;
  localparam int ChannelsPerDriver = 24;
  localparam int StoreDepth        = MaxDrivers * ChannelsPerDriver;
  localparam int AddrW             = $clog2(StoreDepth);
  localparam int ChanW             = $clog2(StoreDepth + 1);
  localparam int WideW             = 12;  // holds 3 * 1023 + 2
  localparam int LevelW            = 12;
  localparam int InLevelW          = 16;
  localparam int CfgW              = 3;

  localparam logic [InLevelW-1:0] LevelMax = 16'd4095;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_RGB   = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [9:0]          index;
    logic [InLevelW-1:0] level_a;
    logic [InLevelW-1:0] level_b;
    logic [InLevelW-1:0] level_c;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [LevelW-1:0]     read_level;
    logic [2*LevelW-1:0]   frame_word;
    logic                  last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic set_wr;
    logic rgb_start;
    logic rgb_g;
    logic rgb_b;
    logic get_rd;
    logic get_emit;
    logic fl_start;
    logic fl_emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic flush_none;
    logic hi_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [LevelW-1:0] clamp_level(input logic [InLevelW-1:0] v);
    logic [LevelW-1:0] r;
    r = (v > LevelMax) ? {LevelW{1'b1}} : v[LevelW-1:0];
    return r;
  endfunction

endpackage

// ===== design/pcfp_ctrl.sv =====
// Command sequencer: decodes items and steps writes, reads and frame emission.
module pcfp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            cmd_i,
  output logic                  in_ready_o,
  input  pcfp_pkg::dp_status_t  status_i,
  output pcfp_pkg::ctl_cmd_t    ctl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RGB_G = 3'd1;
  localparam logic [2:0] ST_RGB_B = 3'd2;
  localparam logic [2:0] ST_GET   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_i)
            pcfp_pkg::CMD_SET: begin
              ctl_o.set_wr = 1'b1;
            end
            pcfp_pkg::CMD_RGB: begin
              ctl_o.rgb_start = 1'b1;
              state_d         = ST_RGB_G;
            end
            pcfp_pkg::CMD_GET: begin
              ctl_o.get_rd = 1'b1;
              state_d      = ST_GET;
            end
            pcfp_pkg::CMD_FLUSH: begin
              // no active channels: nothing to send
              if (!status_i.flush_none) begin
                ctl_o.fl_start = 1'b1;
                state_d        = ST_FLUSH;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RGB_G: begin
        ctl_o.rgb_g = 1'b1;
        state_d     = ST_RGB_B;
      end
      ST_RGB_B: begin
        ctl_o.rgb_b = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_GET: begin
        if (status_i.out_free) begin
          ctl_o.get_emit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          ctl_o.fl_emit = 1'b1;
          if (status_i.hi_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pcfp_datapath.sv =====
// Level store, driver count register, address and range logic, output register.
module pcfp_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pcfp_pkg::in_item_t                   in_data_i,
  input  logic                                 cfg_valid_i,
  input  logic [pcfp_pkg::CfgW-1:0]            cfg_data_i,
  input  pcfp_pkg::ctl_cmd_t                   ctl_i,
  output pcfp_pkg::dp_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output pcfp_pkg::out_item_t                  out_data_o
);

  localparam int AW = pcfp_pkg::AddrW;
  localparam int CW = pcfp_pkg::ChanW;
  localparam int WW = pcfp_pkg::WideW;
  localparam int LW = pcfp_pkg::LevelW;

  logic [pcfp_pkg::CfgW-1:0] nd_q;
  logic [pcfp_pkg::CfgW-1:0] nd_eff;
  logic [CW-1:0]             n_chan;
  logic [WW-1:0]             n_wide;

  logic [LW-1:0] mem [pcfp_pkg::StoreDepth];
  logic [pcfp_pkg::StoreDepth-1:0] vld_q;

  logic [WW-1:0] base_q, base_d;
  logic [LW-1:0] lvl_b_q, lvl_c_q;
  logic [CW-1:0] hi_q;
  logic [CW-1:0] hi_next;

  logic [WW-1:0] wr_chan;
  logic [LW-1:0] wr_data;
  logic          wr_req;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          rd_en;
  logic          rd_ok;
  logic [AW-1:0] ra0, ra1;
  logic [LW-1:0] rd0_q, rd1_q;
  logic          rd0_v_q, rd1_v_q;
  logic [LW-1:0] lvl0, lvl1;
  logic          get_ok;

  logic                 out_valid_q;
  pcfp_pkg::out_item_t  out_q;

  // driver count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q <= pcfp_pkg::CfgW'(1);
    end else if (cfg_valid_i) begin
      nd_q <= cfg_data_i;
    end
  end

  assign nd_eff = (nd_q > pcfp_pkg::CfgW'(pcfp_pkg::MaxDrivers))
                  ? pcfp_pkg::CfgW'(pcfp_pkg::MaxDrivers) : nd_q;
  // times 24 = times 16 plus times 8
  assign n_chan = (CW'(nd_eff) << 4) + (CW'(nd_eff) << 3);
  assign n_wide = WW'(n_chan);

  assign base_d  = WW'(in_data_i.index) + (WW'(in_data_i.index) << 1);
  assign hi_next = hi_q - CW'(2);

  // write port
  always_comb begin
    wr_chan = WW'(in_data_i.index);
    wr_data = pcfp_pkg::clamp_level(in_data_i.level_a);
    wr_req  = ctl_i.set_wr | ctl_i.rgb_start | ctl_i.rgb_g | ctl_i.rgb_b;
    if (ctl_i.rgb_start) begin
      wr_chan = base_d;
    end else if (ctl_i.rgb_g) begin
      wr_chan = base_q + WW'(1);
      wr_data = lvl_b_q;
    end else if (ctl_i.rgb_b) begin
      wr_chan = base_q + WW'(2);
      wr_data = lvl_c_q;
    end
  end

  // drop writes at or beyond the active channel count
  assign wr_en   = wr_req && (wr_chan < n_wide);
  assign wr_addr = wr_chan[AW-1:0];

  // read ports
  assign get_ok = WW'(in_data_i.index) < n_wide;

  always_comb begin
    rd_en = 1'b0;
    rd_ok = 1'b1;
    ra0   = '0;
    ra1   = '0;
    if (ctl_i.get_rd) begin
      rd_en = 1'b1;
      rd_ok = get_ok;
      ra0   = get_ok ? in_data_i.index[AW-1:0] : '0;
    end else if (ctl_i.fl_start) begin
      rd_en = 1'b1;
      ra0   = AW'(n_chan - CW'(1));
      ra1   = AW'(n_chan - CW'(2));
    end else if (ctl_i.fl_emit && !status_o.hi_last) begin
      // prefetch the next pair while the current word moves out
      rd_en = 1'b1;
      ra0   = AW'(hi_q - CW'(3));
      ra1   = AW'(hi_q - CW'(4));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_q <= mem[ra0];
      rd1_q <= mem[ra1];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd0_v_q <= 1'b0;
      rd1_v_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd0_v_q <= vld_q[ra0] & rd_ok;
        rd1_v_q <= vld_q[ra1];
      end
    end
  end

  assign lvl0 = rd0_v_q ? rd0_q : '0;
  assign lvl1 = rd1_v_q ? rd1_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rgb_start) begin
      base_q  <= base_d;
      lvl_b_q <= pcfp_pkg::clamp_level(in_data_i.level_b);
      lvl_c_q <= pcfp_pkg::clamp_level(in_data_i.level_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
    end else if (ctl_i.fl_start) begin
      hi_q <= n_chan;
    end else if (ctl_i.fl_emit) begin
      hi_q <= hi_next;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.get_emit || ctl_i.fl_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.get_emit) begin
      out_q.kind       <= pcfp_pkg::KIND_READ;
      out_q.read_level <= lvl0;
      out_q.frame_word <= '0;
      out_q.last       <= 1'b1;
    end else if (ctl_i.fl_emit) begin
      out_q.kind       <= pcfp_pkg::KIND_FRAME;
      out_q.read_level <= '0;
      out_q.frame_word <= {lvl0, lvl1};
      out_q.last       <= status_o.hi_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.flush_none = (n_chan < CW'(2));
  assign status_o.hi_last    = (hi_q == CW'(2));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== design/pwm_channel_frame_packer_core.sv =====
// Top level of the PWM channel frame packer: sequencer plus datapath.
// Set: one store write at accept. RGB set: R, then G and B in states RGB_G and
// RGB_B, one store write port. Get: registered store read, reply loaded in GET
// once the output is free. Flush: two store read ports fetch each pair into
// registers, one word per cycle (12 per driver) while the output is taken.
// Reset: num_drivers = 1, store reads zero via per-entry valid bits, no sweep.
module pwm_channel_frame_packer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pcfp_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcfp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcfp_pkg::CfgW-1:0]     cfg_data_i
);

  pcfp_pkg::ctl_cmd_t   ctl;
  pcfp_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  pcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctl_o      (ctl)
  );

  pcfp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
